/* sv/escape_time_fractal_pixel_macros.svh */
// Assertion macros used by the checker file of the escape-time pixel block.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ETFP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ETFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/etfp_pkg.sv */
// Package: widths, constants, types and helpers for the escape-time pixel block.
`default_nettype none

package etfp_pkg;

    // Fixed point format of points and constants
    localparam int FRAC_BITS = 28;
    localparam int IN_W      = 32;
    // Iterate width: |re| < 12 and |im| < 16 after an update with |c| < 8
    localparam int Z_W       = IN_W + 4;
    // Multiplier operands: only formed while |re| < 2 and |im| < 2
    localparam int MUL_W     = FRAC_BITS + 2;
    localparam int P_W       = 2 * MUL_W;
    localparam int S_W       = P_W - FRAC_BITS;

    localparam int COUNT_W     = 16;
    localparam int COLOR_W     = 8;
    // Power of two, so the modulo is a mask
    localparam int COLOR_COUNT = 256;

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_C_REAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_C_IMAG = 2'd3;
    localparam logic [COUNT_W-1:0]   STEP_LIMIT_RST   = 16'd255;

    // Queue between front and engine
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // Escape thresholds in iterate format
    localparam logic signed [Z_W-1:0] TWO  = Z_W'(2) << FRAC_BITS;
    localparam logic signed [Z_W-1:0] FOUR = Z_W'(4) << FRAC_BITS;

    // Configuration as seen by front and engine
    typedef struct packed {
        logic                     julia_mode;
        logic [COUNT_W-1:0]       step_limit;
        logic signed [IN_W-1:0]   julia_c_real;
        logic signed [IN_W-1:0]   julia_c_imag;
    } cfg_t;

    // One prepared request: start value of z and the constant c
    typedef struct packed {
        logic signed [Z_W-1:0]  zr;
        logic signed [Z_W-1:0]  zi;
        logic signed [IN_W-1:0] cr;
        logic signed [IN_W-1:0] ci;
    } item_t;

    // Queue status
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    // Sign-extend a point coordinate to iterate width
    function automatic logic signed [Z_W-1:0] sext_in(input logic signed [IN_W-1:0] x);
        sext_in = {{(Z_W - IN_W){x[IN_W-1]}}, x};
    endfunction

endpackage

`default_nettype wire

/* sv/escape_time_fractal_pixel.sv */
// Each request runs n iterations (n <= step_limit) in the engine, which takes the next
// request from the queue only once the last result is in the output register. Each
// iteration passes a multiply state and an update state; the three products of z*z are
// formed in parallel, and the box guard or the squared-magnitude test may end the run.
// Front stage and a two-entry queue take up to three requests ahead of the engine.
// Reset (rst_n, async, active low) empties all stages; Mandelbrot, limit 255, zero Julia c.
`default_nettype none

module escape_time_fractal_pixel (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [etfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [etfp_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [etfp_pkg::IN_W-1:0]     point_real,
    input  wire logic signed [etfp_pkg::IN_W-1:0]     point_imag,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [etfp_pkg::COLOR_W-1:0]              color
);
    import etfp_pkg::*;

    cfg_t       cfg_reg;
    fifo_stat_t stat;
    logic       push;
    item_t      push_item;
    logic       pop;
    item_t      pop_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.julia_mode   <= 1'b0;
            cfg_reg.step_limit   <= STEP_LIMIT_RST;
            cfg_reg.julia_c_real <= '0;
            cfg_reg.julia_c_imag <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_JULIA_MODE:   cfg_reg.julia_mode   <= cfg_data[0];
                CFG_STEP_LIMIT:   cfg_reg.step_limit   <= cfg_data[COUNT_W-1:0];
                CFG_JULIA_C_REAL: cfg_reg.julia_c_real <= cfg_data[IN_W-1:0];
                CFG_JULIA_C_IMAG: cfg_reg.julia_c_imag <= cfg_data[IN_W-1:0];
                default:          ;
            endcase
        end
    end

    etfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_real (point_real),
        .point_imag (point_imag),
        .stat       (stat),
        .push       (push),
        .push_item  (push_item)
    );

    etfp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_item),
        .rd_en   (pop),
        .rd_data (pop_item),
        .stat    (stat)
    );

    etfp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .stat      (stat),
        .pop       (pop),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .color     (color)
    );

endmodule

`default_nettype wire

/* sv/etfp_front.sv */
// Front stage: takes requests and sets up start value and constant by mode.
`default_nettype none

module etfp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire etfp_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [etfp_pkg::IN_W-1:0] point_real,
    input  wire logic signed [etfp_pkg::IN_W-1:0] point_imag,
    input  wire etfp_pkg::fifo_stat_t          stat,
    output logic                               push,
    output etfp_pkg::item_t                    push_item
);
    import etfp_pkg::*;

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    item_t item_new;
    logic  accept;

    // Mandelbrot: z from zero, c is the point. Julia: z is the point, c configured.
    always_comb
    begin
        if (cfg.julia_mode)
        begin
            item_new.zr = sext_in(point_real);
            item_new.zi = sext_in(point_imag);
            item_new.cr = cfg.julia_c_real;
            item_new.ci = cfg.julia_c_imag;
        end
        else
        begin
            item_new.zr = '0;
            item_new.zi = '0;
            item_new.cr = point_real;
            item_new.ci = point_imag;
        end
    end

    // Holding stage drains into the queue whenever there is room
    assign push      = hold_valid_reg && !stat.full;
    assign in_ready  = !hold_valid_reg || !stat.full;
    assign accept    = in_valid && in_ready;
    assign push_item = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= item_new;
        end
    end

endmodule

`default_nettype wire

/* sv/etfp_fifo.sv */
// Short request queue between front and engine, registered read data.
`default_nettype none

module etfp_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire etfp_pkg::item_t   wr_data,
    input  wire logic              rd_en,
    output etfp_pkg::item_t        rd_data,
    output etfp_pkg::fifo_stat_t   stat
);
    import etfp_pkg::*;

    item_t                  mem_reg [FIFO_DEPTH];
    item_t                  rd_data_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  cnt_reg;
    logic [FIFO_CNT_W-1:0]  cnt_next;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_data    = rd_data_reg;

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    // Storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_ptr_reg];
        end
    end

endmodule

`default_nettype wire

/* sv/etfp_engine.sv */
// Iteration engine: z = z*z + c with escape test, plus output register.
`default_nettype none

module etfp_engine (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire etfp_pkg::cfg_t            cfg,
    input  wire etfp_pkg::fifo_stat_t      stat,
    output logic                           pop,
    input  wire etfp_pkg::item_t           pop_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [etfp_pkg::COLOR_W-1:0]   color
);
    import etfp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic signed [Z_W-1:0]   zr_reg;
    logic signed [Z_W-1:0]   zi_reg;
    logic signed [IN_W-1:0]  cr_reg;
    logic signed [IN_W-1:0]  ci_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic signed [Z_W-1:0]   rr_reg;
    logic signed [Z_W-1:0]   ii_reg;
    logic signed [Z_W-1:0]   ri_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    logic                    escaped;
    logic                    at_limit;
    logic                    sq_escape;
    logic                    out_free;
    logic                    emit;
    logic signed [MUL_W-1:0] op_re;
    logic signed [MUL_W-1:0] op_im;
    logic signed [P_W-1:0]   prod_rr;
    logic signed [P_W-1:0]   prod_ii;
    logic signed [P_W-1:0]   prod_ri;
    logic signed [S_W-1:0]   fl_rr;
    logic signed [S_W-1:0]   fl_ii;
    logic signed [S_W-1:0]   fl_ri;
    logic signed [Z_W-1:0]   zr_new;
    logic signed [Z_W-1:0]   zi_new;

    // Box guard on the current iterate, and the step limit
    assign escaped  = (zr_reg >= TWO) || (zr_reg <= -TWO) ||
                      (zi_reg >= TWO) || (zi_reg <= -TWO);
    assign at_limit = (count_reg >= cfg.step_limit);

    // Three products; operands fit MUL_W once the guard has passed
    assign op_re   = zr_reg[MUL_W-1:0];
    assign op_im   = zi_reg[MUL_W-1:0];
    assign prod_rr = op_re * op_re;
    assign prod_ii = op_im * op_im;
    assign prod_ri = op_re * op_im;
    // Arithmetic shift of the exact product is the floor
    assign fl_rr   = prod_rr[P_W-1:FRAC_BITS];
    assign fl_ii   = prod_ii[P_W-1:FRAC_BITS];
    assign fl_ri   = prod_ri[P_W-1:FRAC_BITS];

    // Escape on the floored squares, and the update
    assign sq_escape = (rr_reg + ii_reg) >= FOUR;
    assign zr_new    = rr_reg - ii_reg + sext_in(cr_reg);
    assign zi_new    = (ri_reg <<< 1) + sext_in(ci_reg);

    // Output register is free when empty or being taken
    assign out_free = !out_valid_reg || out_ready;
    assign emit     = (state_reg == ST_DONE) && out_free;
    assign pop      = (state_reg == ST_IDLE) && !stat.empty;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (at_limit || escaped)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (sq_escape)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_LOAD)
            begin
                count_reg <= '0;
            end
            else if ((state_reg == ST_UPD) && !sq_escape)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            zr_reg <= pop_item.zr;
            zi_reg <= pop_item.zi;
            cr_reg <= pop_item.cr;
            ci_reg <= pop_item.ci;
        end
        else if ((state_reg == ST_UPD) && !sq_escape)
        begin
            zr_reg <= zr_new;
            zi_reg <= zi_new;
        end
        if (state_reg == ST_MUL)
        begin
            rr_reg <= {{(Z_W - S_W){fl_rr[S_W-1]}}, fl_rr};
            ii_reg <= {{(Z_W - S_W){fl_ii[S_W-1]}}, fl_ii};
            ri_reg <= {{(Z_W - S_W){fl_ri[S_W-1]}}, fl_ri};
        end
        // Count modulo the colour count, a mask since it is a power of two
        if (emit)
        begin
            color_reg <= COLOR_W'(count_reg & COUNT_W'(COLOR_COUNT - 1));
        end
    end

    assign out_valid = out_valid_reg;
    assign color     = color_reg;

endmodule

`default_nettype wire

/* sv/etfp_checker.sv */
// Port checker for the escape-time pixel block, and its bind to the top level.
`default_nettype none

`include "escape_time_fractal_pixel_macros.svh"

module etfp_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [etfp_pkg::COLOR_W-1:0]    color
);
    // Front stage, two queue entries, engine, output register
    localparam logic [2:0] CAPACITY = 3'd5;

    logic [2:0] pending_reg;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // Requests taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            pending_reg <= pending_reg + 3'd1;
        end
        else if (out_take && !in_take)
        begin
            pending_reg <= pending_reg - 3'd1;
        end
    end

    `ETFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(color), "stalled result changed")
    `ETFP_ASSERT_IMPLY(a_no_spurious, out_valid, pending_reg != 3'd0, "result without request")
    `ETFP_ASSERT_IMPLY(a_capacity, in_take, pending_reg != CAPACITY, "request taken beyond capacity")

endmodule

bind escape_time_fractal_pixel etfp_checker u_etfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .color     (color)
);

`default_nettype wire
